// ----- rtl/lpm_pkg.sv -----
// Package for the latency percentile monitor: commands, states and constants.
`default_nettype none
package lpm_pkg;

  localparam int unsigned DefSampleDepth = 256;
  localparam int unsigned DefSampleWidth = 32;

  localparam int unsigned NumChannels = 3;

  // Reciprocal of 100 scaled by 2**RecipShift, rounded down; one correction step follows.
  localparam int unsigned RecipShift = 20;
  localparam int unsigned Recip100   = 10485;
  localparam int unsigned PctWidth   = 7;

  localparam int unsigned InDataWidth  = 72;
  localparam int unsigned OutDataWidth = 184;

  typedef enum logic [2:0] {
    CMD_CLEAR    = 3'd0,
    CMD_BEGIN    = 3'd1,
    CMD_SKIP     = 3'd2,
    CMD_REC_FRM  = 3'd3,
    CMD_REC_BLD  = 3'd4,
    CMD_REC_WAIT = 3'd5,
    CMD_SUMMARY  = 3'd6,
    CMD_NOP      = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    CH_FRAME = 2'd0,
    CH_BUILD = 2'd1,
    CH_WAIT  = 2'd2
  } chan_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RMUL,
    ST_RDIV,
    ST_RFIX,
    ST_CAND,
    ST_LOAD,
    ST_SCAN,
    ST_EVAL,
    ST_EMIT
  } state_e;

  function automatic logic [PctWidth-1:0] pct_of(input logic [1:0] k);
    case (k)
      2'd0:    pct_of = PctWidth'(50);
      2'd1:    pct_of = PctWidth'(95);
      default: pct_of = PctWidth'(99);
    endcase
  endfunction

endpackage
`default_nettype wire

// ----- rtl/latency_percentile_monitor_top.sv -----
// Top level of the latency percentile monitor: sample rings and rank selection.
//
//  Channel  | Dir | Word content (low bits first)
//  s_axis   | in  | command[2:0], sample_time[34:3], deadline[66:35]
//  m_axis   | out | channel, ring count, median, p95, p99, max, deadline, misses; tlast
//
// Every command except summary takes one memory write at most.
// A summary walks each ring with a single read port: for every candidate sample
// the whole ring is scanned to count smaller and equal samples, and each ring's
// result waits for the output slot. Reset clears counts, positions, skip flag and
// deadline; the sample memory is not cleared. Input is taken only while no summary
// is in progress.
`default_nettype none
module latency_percentile_monitor_top #(
  parameter int unsigned SAMPLE_DEPTH = lpm_pkg::DefSampleDepth,
  parameter int unsigned SAMPLE_WIDTH = lpm_pkg::DefSampleWidth
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // command[2:0], sample_time[34:3], deadline[66:35], zero pad
  input  wire logic [lpm_pkg::InDataWidth-1:0]   s_axis_tdata,
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // channel[1:0], ring_count[10:2], median_time[42:11], pct95_time[74:43],
  // pct99_time[106:75], max_time[138:107], saved_deadline_out[170:139],
  // miss_count[179:171], zero pad
  output      logic [lpm_pkg::OutDataWidth-1:0]  m_axis_tdata,
  output      logic                              m_axis_tlast
);

  localparam int unsigned AW   = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(SAMPLE_DEPTH + 1);
  localparam int unsigned MD   = 3 * SAMPLE_DEPTH;
  localparam int unsigned MAW  = $clog2(MD);
  localparam int unsigned SW   = SAMPLE_WIDTH;
  localparam int unsigned CMPW = (SW > 32) ? SW : 32;
  localparam int unsigned XW   = CW + lpm_pkg::PctWidth;
  localparam int unsigned PW   = XW + 14;

  logic [SW-1:0] mem [MD];
  logic [SW-1:0] rdata_q;
  logic          we;
  logic [MAW-1:0] waddr, raddr;
  logic [SW-1:0] wdata;

  lpm_pkg::state_e state_q, state_d;
  logic [2:0][AW-1:0] wpos_q, wpos_d;
  logic [2:0][CW-1:0] cnt_q, cnt_d;
  logic          skip_q, skip_d;
  logic [31:0]   dl_q, dl_d;
  logic [1:0]    ch_q, ch_d;
  logic [CW-1:0] n_q, n_d;
  logic [1:0]    pk_q, pk_d;
  logic [XW-1:0] x_q, x_d, q_q, q_d;
  logic [2:0][AW-1:0] rank_q, rank_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic          pend_q, pend_d;
  logic [SW-1:0] cand_q, cand_d;
  logic [CW-1:0] less_q, less_d, leq_q, leq_d, miss_q, miss_d;
  logic [3:0][SW-1:0] res_q, res_d;
  logic          ov_q, ov_d, olast_q, olast_d;
  logic [lpm_pkg::OutDataWidth-1:0] odata_q, odata_d;

  logic [2:0]    cmd;
  logic [31:0]   in_time, in_dl;
  logic          s_acc;

  assign cmd     = s_axis_tdata[2:0];
  assign in_time = s_axis_tdata[34:3];
  assign in_dl   = s_axis_tdata[66:35];
  assign s_axis_tready = (state_q == lpm_pkg::ST_IDLE);
  assign s_acc   = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = olast_q;

  function automatic logic [MAW-1:0] base_of(input logic [1:0] c);
    case (c)
      lpm_pkg::CH_FRAME: base_of = '0;
      lpm_pkg::CH_BUILD: base_of = MAW'(SAMPLE_DEPTH);
      default:           base_of = MAW'(2 * SAMPLE_DEPTH);
    endcase
  endfunction

  always_comb begin
    logic [1:0]    rch;
    logic          start;
    logic [1:0]    nch;
    logic [XW-1:0] rem, qq;
    logic [CW-1:0] rk;
    logic [PW-1:0] prod;

    state_d = state_q;
    wpos_d  = wpos_q;
    cnt_d   = cnt_q;
    skip_d  = skip_q;
    dl_d    = dl_q;
    ch_d    = ch_q;
    n_d     = n_q;
    pk_d    = pk_q;
    x_d     = x_q;
    q_d     = q_q;
    rank_d  = rank_q;
    i_d     = i_q;
    j_d     = j_q;
    pend_d  = 1'b0;
    cand_d  = cand_q;
    less_d  = less_q;
    leq_d   = leq_q;
    miss_d  = miss_q;
    res_d   = res_q;
    ov_d    = ov_q;
    olast_d = olast_q;
    odata_d = odata_q;
    we      = 1'b0;
    waddr   = '0;
    raddr   = '0;
    wdata   = (|(in_time >> SW)) ? {SW{1'b1}} : SW'(in_time);
    start   = 1'b0;
    nch     = '0;
    rch     = 2'(cmd - lpm_pkg::CMD_REC_FRM);
    rem     = '0;
    qq      = '0;
    rk      = '0;
    prod    = '0;

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      lpm_pkg::ST_IDLE: begin
        if (s_acc) begin
          case (cmd)
            lpm_pkg::CMD_CLEAR: begin
              wpos_d = '0;
              cnt_d  = '0;
              skip_d = 1'b0;
              dl_d   = '0;
            end
            lpm_pkg::CMD_BEGIN: skip_d = 1'b0;
            lpm_pkg::CMD_SKIP:  skip_d = 1'b1;
            lpm_pkg::CMD_REC_FRM, lpm_pkg::CMD_REC_BLD, lpm_pkg::CMD_REC_WAIT: begin
              if (!skip_q) begin
                we    = 1'b1;
                waddr = base_of(rch) + MAW'(wpos_q[rch]);
                wpos_d[rch] = (wpos_q[rch] == AW'(SAMPLE_DEPTH - 1)) ? '0 : wpos_q[rch] + 1'b1;
                if (cnt_q[rch] != CW'(SAMPLE_DEPTH)) begin
                  cnt_d[rch] = cnt_q[rch] + 1'b1;
                end
                if (cmd == lpm_pkg::CMD_REC_FRM) begin
                  dl_d = in_dl;
                end
              end
            end
            lpm_pkg::CMD_SUMMARY: begin
              start = 1'b1;
              nch   = lpm_pkg::CH_FRAME;
            end
            default: ;
          endcase
        end
      end
      lpm_pkg::ST_RMUL: begin
        x_d = XW'(n_q) * XW'(lpm_pkg::pct_of(pk_q)) + XW'(99);
        state_d = lpm_pkg::ST_RDIV;
      end
      lpm_pkg::ST_RDIV: begin
        prod = PW'(x_q) * PW'(lpm_pkg::Recip100);
        q_d  = XW'(prod >> lpm_pkg::RecipShift);
        state_d = lpm_pkg::ST_RFIX;
      end
      lpm_pkg::ST_RFIX: begin
        // The estimated quotient is low by at most one.
        rem = x_q - XW'(q_q * XW'(100));
        qq  = (rem >= XW'(100)) ? q_q + 1'b1 : q_q;
        rank_d[pk_q] = AW'(qq - 1'b1);
        if (pk_q == 2'd2) begin
          i_d = '0;
          state_d = lpm_pkg::ST_CAND;
        end else begin
          pk_d = pk_q + 1'b1;
          state_d = lpm_pkg::ST_RMUL;
        end
      end
      lpm_pkg::ST_CAND: begin
        raddr = base_of(ch_q) + MAW'(i_q);
        state_d = lpm_pkg::ST_LOAD;
      end
      lpm_pkg::ST_LOAD: begin
        cand_d = rdata_q;
        j_d    = '0;
        less_d = '0;
        leq_d  = '0;
        state_d = lpm_pkg::ST_SCAN;
      end
      lpm_pkg::ST_SCAN: begin
        if (j_q != n_q) begin
          raddr  = base_of(ch_q) + MAW'(j_q);
          j_d    = j_q + 1'b1;
          pend_d = 1'b1;
        end
        if (pend_q) begin
          if (rdata_q < cand_q) less_d = less_q + 1'b1;
          if (rdata_q <= cand_q) leq_d = leq_q + 1'b1;
          // Deadline misses are counted once, on the first scan of the frame ring.
          if (ch_q == lpm_pkg::CH_FRAME && i_q == '0 && dl_q != '0 &&
              CMPW'(rdata_q) > CMPW'(dl_q)) begin
            miss_d = miss_q + 1'b1;
          end
        end
        if (j_q == n_q && !pend_q) begin
          state_d = lpm_pkg::ST_EVAL;
        end
      end
      lpm_pkg::ST_EVAL: begin
        for (int k = 0; k < 4; k++) begin
          rk = (k < 3) ? CW'(rank_q[k]) : n_q - 1'b1;
          if (less_q <= rk && rk < leq_q) begin
            res_d[k] = cand_q;
          end
        end
        i_d = i_q + 1'b1;
        state_d = (i_q + 1'b1 == n_q) ? lpm_pkg::ST_EMIT : lpm_pkg::ST_CAND;
      end
      lpm_pkg::ST_EMIT: begin
        if (!ov_q || m_axis_tready) begin
          ov_d    = 1'b1;
          olast_d = (ch_q == lpm_pkg::CH_WAIT);
          odata_d = '0;
          odata_d[1:0]     = ch_q;
          odata_d[10:2]    = 9'(n_q);
          odata_d[42:11]   = 32'(res_q[0]);
          odata_d[74:43]   = 32'(res_q[1]);
          odata_d[106:75]  = 32'(res_q[2]);
          odata_d[138:107] = 32'(res_q[3]);
          odata_d[170:139] = (ch_q == lpm_pkg::CH_FRAME) ? dl_q : 32'd0;
          odata_d[179:171] = 9'(miss_q);
          if (ch_q == lpm_pkg::CH_WAIT) begin
            state_d = lpm_pkg::ST_IDLE;
          end else begin
            start = 1'b1;
            nch   = ch_q + 1'b1;
          end
        end
      end
      default: state_d = lpm_pkg::ST_IDLE;
    endcase

    if (start) begin
      ch_d   = nch;
      n_d    = cnt_q[nch];
      pk_d   = '0;
      i_d    = '0;
      res_d  = '0;
      miss_d = '0;
      state_d = (cnt_q[nch] == '0) ? lpm_pkg::ST_EMIT : lpm_pkg::ST_RMUL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpm_pkg::ST_IDLE;
      wpos_q  <= '0;
      cnt_q   <= '0;
      skip_q  <= 1'b0;
      dl_q    <= '0;
      ov_q    <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wpos_q  <= wpos_d;
      cnt_q   <= cnt_d;
      skip_q  <= skip_d;
      dl_q    <= dl_d;
      ov_q    <= ov_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q    <= ch_d;
    n_q     <= n_d;
    pk_q    <= pk_d;
    x_q     <= x_d;
    q_q     <= q_d;
    rank_q  <= rank_d;
    i_q     <= i_d;
    j_q     <= j_d;
    cand_q  <= cand_d;
    less_q  <= less_d;
    leq_q   <= leq_d;
    miss_q  <= miss_d;
    res_q   <= res_d;
    olast_q <= olast_d;
    odata_q <= odata_d;
  end

  a_last_is_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && olast_q) |-> (odata_q[1:0] == lpm_pkg::CH_WAIT))
    else $error("final summary word is not the present-wait ring");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q[0] <= CW'(SAMPLE_DEPTH)) && (cnt_q[1] <= CW'(SAMPLE_DEPTH)) &&
    (cnt_q[2] <= CW'(SAMPLE_DEPTH)))
    else $error("ring sample count above depth");

  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpm_pkg::ST_EVAL) |-> (leq_q >= less_q) && (leq_q != '0))
    else $error("candidate rank counts inconsistent");

  a_summary_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && cmd == lpm_pkg::CMD_SUMMARY) |=> (state_q != lpm_pkg::ST_IDLE))
    else $error("summary request did not start a walk");

endmodule
`default_nettype wire
